### design/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg: shared constants for the quaternion to Euler angle converter
// Widths, CORDIC step count, square root stage split and the arctangent table.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Stream field widths.
  localparam int COMP_W  = 16;
  localparam int ANGLE_W = 16;
  localparam int IN_W    = 4 * COMP_W;
  localparam int OUT_W   = 3 * ANGLE_W;

  // Micro-rotation count; the table holds 24 entries, more steps act as 24.
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int STEPS        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int CORDIC_LAT   = STEPS + 2;

  // Arctangent datapath widths.
  localparam int PROD_W   = 2 * COMP_W;
  localparam int VEC_W    = 34;
  localparam int MAG_W    = VEC_W + 1;
  localparam int ROT_W    = 45;
  localparam int ACC_W    = 32;
  localparam int SHIFT_W  = 6;
  localparam int NORM_MSB = 40;

  // Angle constants with pi = 2^31.
  localparam logic [ACC_W-1:0] HALF_PI     = 32'h4000_0000;
  localparam logic [ACC_W-1:0] NEG_HALF_PI = 32'hC000_0000;

  // Pitch root arguments and the digit-by-digit square root.
  localparam int ARG_W          = 35;
  localparam int ISQ_IN_W       = 50;
  localparam int ISQ_ROOT_W     = ISQ_IN_W / 2;
  localparam int ISQ_REM_W      = ISQ_ROOT_W + 3;
  localparam int ISQ_PER_STAGE  = 5;
  localparam int ISQ_STAGES     = (ISQ_ROOT_W + ISQ_PER_STAGE - 1) / ISQ_PER_STAGE;

  // Total register stages from input transfer to output register.
  localparam int PIPE_LEN = 2 + ISQ_STAGES + CORDIC_LAT + 1;

  // atan(2^-i) with pi = 2^31.
  function automatic logic [ACC_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2F9;
      5'd15:   v = 32'h0000_517C;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A2F;
      5'd19:   v = 32'h0000_0517;
      5'd20:   v = 32'h0000_028B;
      5'd21:   v = 32'h0000_0145;
      5'd22:   v = 32'h0000_00A2;
      5'd23:   v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### design/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
`default_nettype none
// Input to output: product register, argument register, square root stages, CORDIC lanes, output register.
// Throughput: one quaternion per cycle while the output is not stalled; each CORDIC
// micro-rotation and each group of five square root digits has its own register stage.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears only the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to roll, pitch and yaw
// Product stage, pitch root arguments, pipelined square roots, three CORDIC
// arctangent lanes and a final rounding stage.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  wire logic [q2e_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
  output logic      [q2e_pkg::OUT_W-1:0]    m_axis_tdata,
  // root_clamped [0]
  output logic      [0:0]                   m_axis_tuser
);
  import q2e_pkg::*;

  logic                      en;
  logic [PIPE_LEN-1:0]       valid;
  logic signed [COMP_W-1:0]  qw, qx, qy, qz;
  logic signed [PROD_W-1:0]  p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_xz;
  logic signed [VEC_W-1:0]   roll_y_c, roll_x_c, yaw_y_c, yaw_x_c;
  logic signed [ARG_W-1:0]   s_c, pa_c, pb_c;
  logic signed [VEC_W-1:0]   roll_y [0:ISQ_STAGES];
  logic signed [VEC_W-1:0]   roll_x [0:ISQ_STAGES];
  logic signed [VEC_W-1:0]   yaw_y  [0:ISQ_STAGES];
  logic signed [VEC_W-1:0]   yaw_x  [0:ISQ_STAGES];
  logic        [ISQ_IN_W-1:0]   isq_n    [0:ISQ_STAGES][0:1];
  logic        [ISQ_REM_W-1:0]  isq_rem  [0:ISQ_STAGES][0:1];
  logic        [ISQ_ROOT_W-1:0] isq_root [0:ISQ_STAGES][0:1];
  logic        [ISQ_REM_W-1:0]  rem_nx   [1:ISQ_STAGES][0:1];
  logic        [ISQ_ROOT_W-1:0] root_nx  [1:ISQ_STAGES][0:1];
  logic        clamp_d [0:ISQ_STAGES+CORDIC_LAT];
  logic signed [VEC_W-1:0]   pitch_y, pitch_x;
  logic [ACC_W-1:0]          roll_acc, yaw_acc, pitch_acc;
  logic signed [ACC_W-1:0]   za;
  logic signed [ACC_W:0]     zc, p_round;
  logic [ACC_W-1:0]          roll_rnd, yaw_rnd;

  // Global advance: the pipeline moves unless the output holds an untaken result.
  assign en            = !valid[PIPE_LEN-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[PIPE_LEN-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: all products of the components.
  assign qw = s_axis_tdata[COMP_W-1:0];
  assign qx = s_axis_tdata[2*COMP_W-1:COMP_W];
  assign qy = s_axis_tdata[3*COMP_W-1:2*COMP_W];
  assign qz = s_axis_tdata[4*COMP_W-1:3*COMP_W];

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_xz <= qx * qz;
    end
  end

  // Stage 2: arctangent arguments and clamped pitch root arguments.
  always_comb begin
    roll_y_c = (VEC_W'(p_wx) + VEC_W'(p_yz)) <<< 1;
    roll_x_c = VEC_W'(HALF_PI) - ((VEC_W'(p_xx) + VEC_W'(p_yy)) <<< 1);
    yaw_y_c  = (VEC_W'(p_wz) + VEC_W'(p_xy)) <<< 1;
    yaw_x_c  = VEC_W'(HALF_PI) - ((VEC_W'(p_yy) + VEC_W'(p_zz)) <<< 1);
    s_c      = ARG_W'(p_wy) - ARG_W'(p_xz);
    pa_c     = ARG_W'(HALF_PI) + (s_c <<< 1);
    pb_c     = ARG_W'(HALF_PI) - (s_c <<< 1);
  end

  // Square roots, five result bits per stage, restoring digit by digit.
  always_comb begin
    logic [ISQ_REM_W-1:0]  rem_t;
    logic [ISQ_ROOT_W-1:0] root_t;
    logic [ISQ_REM_W-1:0]  trial;
    int j;
    for (int k = 0; k < ISQ_STAGES; k++) begin
      for (int l = 0; l < 2; l++) begin
        rem_t  = isq_rem[k][l];
        root_t = isq_root[k][l];
        for (int s = 0; s < ISQ_PER_STAGE; s++) begin
          j = k * ISQ_PER_STAGE + s;
          if (j < ISQ_ROOT_W) begin
            rem_t = {rem_t[ISQ_REM_W-3:0], isq_n[k][l][ISQ_IN_W-1-2*j -: 2]};
            trial = {1'b0, root_t, 2'b01};
            if (rem_t >= trial) begin
              rem_t  = rem_t - trial;
              root_t = {root_t[ISQ_ROOT_W-2:0], 1'b1};
            end else begin
              root_t = {root_t[ISQ_ROOT_W-2:0], 1'b0};
            end
          end
        end
        rem_nx[k+1][l]  = rem_t;
        root_nx[k+1][l] = root_t;
      end
    end
  end

  // Stage 2 register, then the square root stages; the roll and yaw vectors
  // ride along in step.
  always_ff @(posedge clk) begin
    if (en) begin
      roll_y[0]      <= roll_y_c;
      roll_x[0]      <= roll_x_c;
      yaw_y[0]       <= yaw_y_c;
      yaw_x[0]       <= yaw_x_c;
      isq_n[0][0]    <= (pa_c < 0) ? '0 : {pa_c[ISQ_IN_W-17:0], 16'h0000};
      isq_n[0][1]    <= (pb_c < 0) ? '0 : {pb_c[ISQ_IN_W-17:0], 16'h0000};
      isq_rem[0][0]  <= '0;
      isq_rem[0][1]  <= '0;
      isq_root[0][0] <= '0;
      isq_root[0][1] <= '0;
      clamp_d[0]     <= (pa_c < 0) || (pb_c < 0);
      for (int k = 1; k <= ISQ_STAGES; k++) begin
        roll_y[k] <= roll_y[k-1];
        roll_x[k] <= roll_x[k-1];
        yaw_y[k]  <= yaw_y[k-1];
        yaw_x[k]  <= yaw_x[k-1];
        for (int l = 0; l < 2; l++) begin
          isq_n[k][l]    <= isq_n[k-1][l];
          isq_rem[k][l]  <= rem_nx[k][l];
          isq_root[k][l] <= root_nx[k][l];
        end
      end
      for (int k = 1; k <= ISQ_STAGES + CORDIC_LAT; k++) begin
        clamp_d[k] <= clamp_d[k-1];
      end
    end
  end

  // Three arctangent lanes.
  assign pitch_y = VEC_W'(isq_root[ISQ_STAGES][0]);
  assign pitch_x = VEC_W'(isq_root[ISQ_STAGES][1]);

  q2e_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .vec_y (roll_y[ISQ_STAGES]),
    .vec_x (roll_x[ISQ_STAGES]),
    .angle (roll_acc)
  );

  q2e_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .vec_y (yaw_y[ISQ_STAGES]),
    .vec_x (yaw_x[ISQ_STAGES]),
    .angle (yaw_acc)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .vec_y (pitch_y),
    .vec_x (pitch_x),
    .angle (pitch_acc)
  );

  // Rounding; the pitch arctangent is clamped to 0..pi/2 and mapped to -pi/2..pi/2.
  always_comb begin
    roll_rnd = roll_acc + 32'h0000_8000;
    yaw_rnd  = yaw_acc + 32'h0000_8000;
    za       = pitch_acc;
    if (za < 0) begin
      zc = '0;
    end else if (za > $signed(HALF_PI)) begin
      zc = (ACC_W+1)'(HALF_PI);
    end else begin
      zc = (ACC_W+1)'(za);
    end
    p_round = (zc <<< 1) - (ACC_W+1)'(HALF_PI) + (ACC_W+1)'(32'h0000_8000);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata[ANGLE_W-1:0]           <= roll_rnd[ACC_W-1:ACC_W-ANGLE_W];
      m_axis_tdata[2*ANGLE_W-1:ANGLE_W]   <= p_round[ANGLE_W+15:16];
      m_axis_tdata[3*ANGLE_W-1:2*ANGLE_W] <= yaw_rnd[ACC_W-1:ACC_W-ANGLE_W];
      m_axis_tuser[0]                     <= clamp_d[ISQ_STAGES+CORDIC_LAT];
    end
  end

endmodule
`default_nettype wire

### design/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic: pipelined four-quadrant arctangent
// Normalizes the vector, pre-rotates the left half plane and runs one
// vectoring micro-rotation per register stage.
// ----------------------------------------------------------------------------
module q2e_cordic (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [q2e_pkg::VEC_W-1:0] vec_y,
  input  wire logic signed [q2e_pkg::VEC_W-1:0] vec_x,
  output logic             [q2e_pkg::ACC_W-1:0] angle
);
  import q2e_pkg::*;

  logic signed [MAG_W-1:0]   ext_y, ext_x, mag_y, mag_x, mag_max;
  logic        [SHIFT_W-1:0] msb;
  logic signed [VEC_W-1:0]   a_y, a_x;
  logic        [SHIFT_W-1:0] a_shift;
  logic                      a_zero;
  logic signed [ROT_W-1:0]   sh_y, sh_x;
  logic signed [ROT_W-1:0]   x_s   [0:STEPS];
  logic signed [ROT_W-1:0]   y_s   [0:STEPS];
  logic        [ACC_W-1:0]   acc_s [0:STEPS];
  logic                      zero_s[0:STEPS];
  logic signed [ROT_W-1:0]   x_next  [1:STEPS];
  logic signed [ROT_W-1:0]   y_next  [1:STEPS];
  logic        [ACC_W-1:0]   acc_next[1:STEPS];

  // Magnitudes and the position of the leading one of the larger one.
  always_comb begin
    ext_y   = MAG_W'(vec_y);
    ext_x   = MAG_W'(vec_x);
    mag_y   = (ext_y < 0) ? -ext_y : ext_y;
    mag_x   = (ext_x < 0) ? -ext_x : ext_x;
    mag_max = (mag_x > mag_y) ? mag_x : mag_y;
    msb     = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag_max[i]) begin
        msb = SHIFT_W'(i);
      end
    end
  end

  // Stage A: hold the vector with its normalizing shift.
  always_ff @(posedge clk) begin
    if (en) begin
      a_y     <= vec_y;
      a_x     <= vec_x;
      a_shift <= SHIFT_W'(NORM_MSB) - msb;
      a_zero  <= (mag_max == '0);
    end
  end

  // Stage B: shift left and rotate the left half plane by a quarter turn.
  always_comb begin
    sh_y = ROT_W'(a_y) <<< a_shift;
    sh_x = ROT_W'(a_x) <<< a_shift;
  end

  // One vectoring micro-rotation per stage, driving y toward zero.
  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      if (y_s[i] >= 0) begin
        x_next[i+1]   = x_s[i] + (y_s[i] >>> i);
        y_next[i+1]   = y_s[i] - (x_s[i] >>> i);
        acc_next[i+1] = acc_s[i] + atan_entry(5'(i));
      end else begin
        x_next[i+1]   = x_s[i] - (y_s[i] >>> i);
        y_next[i+1]   = y_s[i] + (x_s[i] >>> i);
        acc_next[i+1] = acc_s[i] - atan_entry(5'(i));
      end
    end
  end

  // Stage B register followed by the micro-rotation registers.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_s[0] <= a_zero;
      if (sh_x < 0) begin
        if (sh_y >= 0) begin
          x_s[0]   <= sh_y;
          y_s[0]   <= -sh_x;
          acc_s[0] <= HALF_PI;
        end else begin
          x_s[0]   <= -sh_y;
          y_s[0]   <= sh_x;
          acc_s[0] <= NEG_HALF_PI;
        end
      end else begin
        x_s[0]   <= sh_x;
        y_s[0]   <= sh_y;
        acc_s[0] <= '0;
      end
      for (int i = 1; i <= STEPS; i++) begin
        x_s[i]    <= x_next[i];
        y_s[i]    <= y_next[i];
        acc_s[i]  <= acc_next[i];
        zero_s[i] <= zero_s[i-1];
      end
    end
  end

  // A zero vector answers angle zero.
  assign angle = zero_s[STEPS] ? '0 : acc_s[STEPS];

endmodule
`default_nettype wire

### dv/quaternion_to_euler_angles_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_test: self-checking bench for the converter
// Drives quaternions over the input stream (directed table, then random unit,
// raw and small quaternions) and checks roll, pitch, yaw and the clamp flag of
// every output transfer against a bit-exact predictor of the CORDIC datapath.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_test;
  import q2e_pkg::*;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic        clamped;
  } angles_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 335;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  angles_t expected_angles[$];
  int errors = 0;
  int phase = 0;
  int hold_requests = 0;
  int idle_cycles = 0;

  quaternion_to_euler_angles dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Arctangent of 2^-i with pi = 2^31.
  localparam logic [31:0] ATAN_ROM [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Four-quadrant CORDIC vectoring; angle modulo 2^32 with pi = 2^31.
  function automatic logic [31:0] cordic_atan2(longint y, longint x);
    logic [31:0] acc;
    longint m, t, xs, ys;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    m = (abs64(x) > abs64(y)) ? abs64(x) : abs64(y);
    while (m < (64'sd1 <<< NORM_MSB)) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = HALF_PI;
      end else begin
        x = -y; y = t; acc = NEG_HALF_PI;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc = acc + ATAN_ROM[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - ATAN_ROM[i];
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h8000;
    return r[31:16];
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic angles_t euler_from_quat(logic [IN_W-1:0] d);
    angles_t r;
    longint w, x, y, z, one, s, pa, pb, zc, p;
    longint unsigned ra, rb;
    logic [31:0] za;
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    one = 64'sd1 <<< 30;
    r.roll = round_angle(cordic_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    r.yaw  = round_angle(cordic_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
    s = w * y - x * z;
    pa = one + 2 * s;
    pb = one - 2 * s;
    r.clamped = 1'b0;
    // A non-unit quaternion can push one root argument below zero.
    if (pa < 0) begin
      pa = 0; r.clamped = 1'b1;
    end
    if (pb < 0) begin
      pb = 0; r.clamped = 1'b1;
    end
    ra = floor_sqrt(longint'(pa) << 16);
    rb = floor_sqrt(longint'(pb) << 16);
    za = cordic_atan2(longint'(ra), longint'(rb));
    zc = longint'($signed(za));
    // Keep the half angle within 0..pi/2 despite CORDIC error.
    if (zc < 0) zc = 0;
    if (zc > longint'(HALF_PI)) zc = longint'(HALF_PI);
    p = 2 * zc - longint'(HALF_PI);
    p = (p + 32'sh8000) >>> 16;
    r.pitch = p[15:0];
    return r;
  endfunction

  // Record each accepted quaternion and check each output transfer.
  always @(posedge clk) begin
    angles_t got, want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_angles.push_back(euler_from_quat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser};
        if (expected_angles.size() == 0) begin
          $error("unexpected output transfer %h", got);
          errors++;
        end else begin
          want = expected_angles.pop_front();
          if (got.roll !== want.roll) begin
            $error("roll_angle: expected %0d, got %0d", $signed(want.roll), $signed(got.roll));
            errors++;
          end
          if (got.pitch !== want.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", $signed(want.pitch),
                   $signed(got.pitch));
            errors++;
          end
          if (got.yaw !== want.yaw) begin
            $error("yaw_angle: expected %0d, got %0d", $signed(want.yaw), $signed(got.yaw));
            errors++;
          end
          if (got.clamped !== want.clamped) begin
            $error("root_clamped: expected %0b, got %0b", want.clamped, got.clamped);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL quaternion_to_euler_angles");
      $finish;
    end
  end

  // Output side: random stalls by phase, plus long hold-offs on request.
  initial begin
    int hold_left, holds_done;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (phase == 2)
        m_axis_tready <= ($urandom_range(99) >= 46);
      else if (phase == 3)
        m_axis_tready <= ($urandom_range(99) >= 35);
      else
        m_axis_tready <= 1'b1;
    end
  end

  // One input transfer, with random idle cycles ahead of it in idle phases.
  task automatic send_quat(quat_t q);
    int pct;
    pct = (phase == 1) ? 46 : (phase == 3) ? 35 : 0;
    @(negedge clk);
    if (pct > 0 && $urandom_range(99) < pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {q.z, q.y, q.x, q.w};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic quat_t random_quat();
    quat_t q;
    real a, b, c, d, n;
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      // Unit quaternion with random direction.
      do begin
        a = $itor($signed($urandom_range(65535) - 32768));
        b = $itor($signed($urandom_range(65535) - 32768));
        c = $itor($signed($urandom_range(65535) - 32768));
        d = $itor($signed($urandom_range(65535) - 32768));
        n = $sqrt(a * a + b * b + c * c + d * d);
      end while (n < 1000.0);
      q.w = 16'($rtoi(a / n * 32767.0));
      q.x = 16'($rtoi(b / n * 32767.0));
      q.y = 16'($rtoi(c / n * 32767.0));
      q.z = 16'($rtoi(d / n * 32767.0));
    end else if (kind < 9) begin
      q.w = 16'($urandom); q.x = 16'($urandom); q.y = 16'($urandom); q.z = 16'($urandom);
    end else begin
      // Small components, exercising the normalizing shift.
      q.w = 16'($signed($urandom_range(64)) - 32);
      q.x = 16'($signed($urandom_range(64)) - 32);
      q.y = 16'($signed($urandom_range(64)) - 32);
      q.z = 16'($signed($urandom_range(64)) - 32);
    end
    return q;
  endfunction

  // Directed quaternions {w, x, y, z}.
  localparam logic signed [15:0] DIRECTED [14][4] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd32767, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd32767, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd32767},
    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
    '{16'sd32767, 16'sd0, 16'sd32767, 16'sd0},
    '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0},
    '{16'sd0, 16'sd16384, 16'sd16384, 16'sd0},
    '{16'sd23170, 16'sd0, 16'sd23170, 16'sd0},
    '{16'sd23170, 16'sd0, -16'sd23170, 16'sd0},
    '{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384}
  };

  initial begin
    quat_t q;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      q.w = DIRECTED[i][0]; q.x = DIRECTED[i][1];
      q.y = DIRECTED[i][2]; q.z = DIRECTED[i][3];
      send_quat(q);
    end
    stop_sending();

    for (int p = 0; p < 4; p++) begin
      // Sender pauses until the pipeline has drained.
      wait (expected_angles.size() == 0);
      phase = p;
      if (p == 0 || p == 2) hold_requests++;
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_quat(random_quat());
      stop_sending();
    end

    wait (expected_angles.size() == 0);
    repeat (PIPE_LEN + 20) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0)
      $display("PASS quaternion_to_euler_angles");
    else
      $display("FAIL quaternion_to_euler_angles");
    $finish;
  end

endmodule

### files.f
design/q2e_pkg.sv
design/q2e_cordic.sv
design/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_test.sv
